// ----- rtl/dct_pkg.sv -----
// Package for the dual down-counter timer.
// Holds the request codes, the register map and the default parameter values.
// Depends on nothing; the timer's top level imports it.
package dct_pkg;

    // Default parameter values.
    localparam int NUM_CHANNELS_DEF  = 2;
    localparam int COUNTER_WIDTH_DEF = 56;

    // Width of one bus word.
    localparam int WORD_WIDTH = 32;

    // Request codes carried by req_type.
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    // Global register offsets and the start of the channel blocks.
    localparam logic [5:0] OFF_IRQ_EN   = 6'h00;
    localparam logic [5:0] OFF_IRQ_STAS = 6'h04;
    localparam logic [5:0] OFF_CH_BASE  = 6'h10;

    // Each channel block spans 32 bytes.
    localparam int CH_STRIDE_LOG2 = 5;

    // Register offsets within a channel block.
    localparam logic [4:0] SUB_CTRL     = 5'h00;
    localparam logic [4:0] SUB_INTV_LO  = 5'h04;
    localparam logic [4:0] SUB_INTV_HI  = 5'h08;
    localparam logic [4:0] SUB_CURNT_LO = 5'h0C;
    localparam logic [4:0] SUB_CURNT_HI = 5'h10;

    // Control register fields.
    localparam int BIT_ENABLE    = 0;
    localparam int BIT_RELOAD    = 1;
    localparam int PRESCALE_LSB  = 4;
    localparam int PRESCALE_MSB  = 6;
    localparam int BIT_SINGLE    = 7;

    // Prescale codes above this value divide by sixteen.
    localparam logic [2:0] MAX_PRESCALE_CODE = 3'd4;

endpackage

// ----- rtl/dual_down_counter_timer.sv -----
// Top level of the dual down-counter timer: register port, prescalers and counters.
// Depends on dct_pkg for the register map and request codes.
// A checker module is bound to this module from dct_checker.sv.

// Each item on the input channel is a clock tick, a register read or a register
// write, and each produces exactly one result item carrying the read data and the
// two interrupt lines as they stand after that item. An item is captured in an
// input register and, once the result register is free or being emptied, processed
// into the result register, which offers it; while the output side is not stalled,
// one item can be accepted every cycle. The per-cycle path is set by the counter
// decrement and compare on the full counter width. A result held by a stalled
// consumer stops the input only once the input register is also full.
module dual_down_counter_timer #(
    parameter int NUM_CHANNELS  = dct_pkg::NUM_CHANNELS_DEF,
    parameter int COUNTER_WIDTH = dct_pkg::COUNTER_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [5:0]  reg_offset,
    input  logic [31:0] write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_data,
    output logic        irq_timer0,
    output logic        irq_timer1
);
    import dct_pkg::*;

    localparam int HI_WIDTH = COUNTER_WIDTH - WORD_WIDTH;

    typedef logic [COUNTER_WIDTH-1:0] count_t;

    // Input register.
    logic        s1_valid_reg;
    logic [1:0]  s1_req_reg;
    logic [5:0]  s1_off_reg;
    logic [31:0] s1_data_reg;

    // Result register.
    logic                    out_valid_reg;
    logic [31:0]             rd_reg;
    logic [NUM_CHANNELS-1:0] irq_reg;

    // Channel state.
    count_t     interval_reg [NUM_CHANNELS];
    count_t     count_reg    [NUM_CHANNELS];
    logic       enable_reg   [NUM_CHANNELS];
    logic       single_reg   [NUM_CHANNELS];
    logic [2:0] code_reg     [NUM_CHANNELS];
    logic [3:0] pre_reg      [NUM_CHANNELS];

    count_t     interval_next [NUM_CHANNELS];
    count_t     count_next    [NUM_CHANNELS];
    logic       enable_next   [NUM_CHANNELS];
    logic       single_next   [NUM_CHANNELS];
    logic [2:0] code_next     [NUM_CHANNELS];
    logic [3:0] pre_next      [NUM_CHANNELS];

    // Interrupt enable and pending bits.
    logic [NUM_CHANNELS-1:0] irq_en_reg;
    logic [NUM_CHANNELS-1:0] irq_en_next;
    logic [NUM_CHANNELS-1:0] pend_reg;
    logic [NUM_CHANNELS-1:0] pend_next;

    logic [31:0]             rd_next;
    logic [NUM_CHANNELS-1:0] irq_next;

    // Decode of the held item.
    logic       advance;
    logic       aligned;
    logic       is_tick;
    logic       is_rd;
    logic       is_wr;
    logic [5:0] rel_off;
    logic       in_ch_range;
    logic       ch_sel;
    logic [4:0] sub_off;
    logic       sub_ok;

    // The held item moves on when the result register is free or being emptied.
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    // Split the offset into channel and register within the channel block.
    assign aligned     = (s1_off_reg[1:0] == 2'b00);
    assign is_tick     = (s1_req_reg == REQ_TICK);
    assign is_rd       = (s1_req_reg == REQ_READ) && aligned;
    assign is_wr       = (s1_req_reg == REQ_WRITE) && aligned;
    assign rel_off     = s1_off_reg - OFF_CH_BASE;
    assign in_ch_range = (s1_off_reg >= OFF_CH_BASE);
    assign ch_sel      = rel_off[CH_STRIDE_LOG2];
    assign sub_off     = rel_off[CH_STRIDE_LOG2-1:0];
    assign sub_ok      = (sub_off <= SUB_CURNT_HI);

    // Next state and result for the held item.
    always_comb
    begin
        logic       ch_hit;
        logic [2:0] eff_code;
        logic [4:0] div;
        logic [4:0] pre_sum;

        ch_hit   = 1'b0;
        eff_code = '0;
        div      = '0;
        pre_sum  = '0;

        rd_next     = '0;
        irq_en_next = irq_en_reg;
        pend_next   = pend_reg;

        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            interval_next[c] = interval_reg[c];
            count_next[c]    = count_reg[c];
            enable_next[c]   = enable_reg[c];
            single_next[c]   = single_reg[c];
            code_next[c]     = code_reg[c];
            pre_next[c]      = pre_reg[c];

            ch_hit = in_ch_range && sub_ok && (ch_sel == 1'(c));

            // A tick steps the prescaler of an enabled channel and, on a divided tick, the counter.
            if (is_tick && enable_reg[c])
            begin
                eff_code = (code_reg[c] > MAX_PRESCALE_CODE) ? MAX_PRESCALE_CODE
                                                              : code_reg[c];
                div      = 5'd1 << eff_code;
                pre_sum  = {1'b0, pre_reg[c]} + 5'd1;
                if (pre_sum < div)
                begin
                    pre_next[c] = pre_sum[3:0];
                end
                else
                begin
                    pre_next[c] = '0;
                    if (count_reg[c] > count_t'(1))
                    begin
                        count_next[c] = count_reg[c] - count_t'(1);
                    end
                    else
                    begin
                        pend_next[c] = 1'b1;
                        if (single_reg[c])
                        begin
                            count_next[c]  = '0;
                            enable_next[c] = 1'b0;
                        end
                        else
                        begin
                            count_next[c] = interval_reg[c];
                        end
                    end
                end
            end

            // Channel register writes.
            if (is_wr && ch_hit)
            begin
                case (sub_off)
                    SUB_CTRL:
                    begin
                        enable_next[c] = s1_data_reg[BIT_ENABLE];
                        single_next[c] = s1_data_reg[BIT_SINGLE];
                        code_next[c]   = s1_data_reg[PRESCALE_MSB:PRESCALE_LSB];
                        pre_next[c]    = '0;
                        if (s1_data_reg[BIT_RELOAD])
                        begin
                            count_next[c] = interval_reg[c];
                        end
                    end
                    SUB_INTV_LO:
                        interval_next[c] = {interval_reg[c][COUNTER_WIDTH-1:WORD_WIDTH],
                                            s1_data_reg};
                    SUB_INTV_HI:
                        interval_next[c] = {s1_data_reg[HI_WIDTH-1:0],
                                            interval_reg[c][WORD_WIDTH-1:0]};
                    SUB_CURNT_LO:
                        count_next[c] = {count_reg[c][COUNTER_WIDTH-1:WORD_WIDTH],
                                         s1_data_reg};
                    SUB_CURNT_HI:
                        count_next[c] = {s1_data_reg[HI_WIDTH-1:0],
                                         count_reg[c][WORD_WIDTH-1:0]};
                    default: ;
                endcase
            end

            // Channel register reads.
            if (is_rd && ch_hit)
            begin
                case (sub_off)
                    SUB_CTRL:
                        rd_next = 32'({single_reg[c], code_reg[c], 3'b000, enable_reg[c]});
                    SUB_INTV_LO:
                        rd_next = interval_reg[c][WORD_WIDTH-1:0];
                    SUB_INTV_HI:
                        rd_next = 32'(interval_reg[c][COUNTER_WIDTH-1:WORD_WIDTH]);
                    SUB_CURNT_LO:
                        rd_next = count_reg[c][WORD_WIDTH-1:0];
                    SUB_CURNT_HI:
                        rd_next = 32'(count_reg[c][COUNTER_WIDTH-1:WORD_WIDTH]);
                    default: ;
                endcase
            end
        end

        // Global interrupt registers.
        if (is_wr && (s1_off_reg == OFF_IRQ_EN))
        begin
            irq_en_next = s1_data_reg[NUM_CHANNELS-1:0];
        end
        if (is_wr && (s1_off_reg == OFF_IRQ_STAS))
        begin
            pend_next = pend_reg & ~s1_data_reg[NUM_CHANNELS-1:0];
        end
        if (is_rd && (s1_off_reg == OFF_IRQ_EN))
        begin
            rd_next = 32'(irq_en_reg);
        end
        if (is_rd && (s1_off_reg == OFF_IRQ_STAS))
        begin
            rd_next = 32'(pend_reg);
        end

        irq_next = pend_next & irq_en_next;
    end

    // Handshake flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item payload in the input and result registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_req_reg  <= req_type;
            s1_off_reg  <= reg_offset;
            s1_data_reg <= write_data;
        end
        if (advance)
        begin
            rd_reg  <= rd_next;
            irq_reg <= irq_next;
        end
    end

    // Timer state, updated as each item is processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                interval_reg[c] <= '0;
                count_reg[c]    <= '0;
                enable_reg[c]   <= 1'b0;
                single_reg[c]   <= 1'b0;
                code_reg[c]     <= '0;
                pre_reg[c]      <= '0;
            end
            irq_en_reg <= '0;
            pend_reg   <= '0;
        end
        else if (advance)
        begin
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                interval_reg[c] <= interval_next[c];
                count_reg[c]    <= count_next[c];
                enable_reg[c]   <= enable_next[c];
                single_reg[c]   <= single_next[c];
                code_reg[c]     <= code_next[c];
                pre_reg[c]      <= pre_next[c];
            end
            irq_en_reg <= irq_en_next;
            pend_reg   <= pend_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = rd_reg;
    assign irq_timer0 = irq_reg[0];

    // The second interrupt line exists only with more than one channel.
    generate
        if (NUM_CHANNELS > 1)
        begin : g_irq1
            assign irq_timer1 = irq_reg[NUM_CHANNELS-1];
        end
        else
        begin : g_no_irq1
            assign irq_timer1 = 1'b0;
        end
    endgenerate

endmodule

// ----- rtl/dct_checker.sv -----
// Port-level checker for the dual down-counter timer, with its bind statement.
// Depends only on the top level's ports; bound to dual_down_counter_timer.
module dct_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  req_type,
    input logic [5:0]  reg_offset,
    input logic [31:0] write_data,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] read_data,
    input logic        irq_timer0,
    input logic        irq_timer1
);

    // A waiting input item keeps its payload until it is taken.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(req_type)
            && $stable(reg_offset) && $stable(write_data))
        else $error("input item changed while waiting");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data)
            && $stable(irq_timer0) && $stable(irq_timer1))
        else $error("result changed while stalled");

    // Every accepted item is followed by a waiting result.
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##2 out_valid)
        else $error("accepted item produced no result");

    // The input is only held off by a stalled result.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input blocked without output back-pressure");

    // A result never appears without an earlier accepted item.
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result appeared without an accepted item");

endmodule

bind dual_down_counter_timer dct_checker u_dct_checker (.*);

// ----- dv/tb_dual_down_counter_timer.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the dual down-counter timer.
// Drives ticks, register reads and writes; checks each result against a typed row's
// result or a cycle-free model of the two channels. Needs dct_pkg and the timer RTL.

module tb_dual_down_counter_timer;
    import dct_pkg::*;

    localparam int NUM_CH = NUM_CHANNELS_DEF;
    localparam int CW     = COUNTER_WIDTH_DEF;

    // Request code that the block must ignore.
    localparam logic [1:0] REQ_IDLE = 2'd3;

    // Channel block bases and offsets with no register behind them.
    localparam logic [5:0] CH0_BASE       = OFF_CH_BASE;
    localparam logic [5:0] CH1_BASE       = OFF_CH_BASE + 6'(1 << CH_STRIDE_LOG2);
    localparam logic [5:0] OFF_GAP        = 6'h08;
    localparam logic [5:0] OFF_MISALIGNED = 6'h13;

    // Control word fields.
    localparam logic [2:0]  PSC_DIV2     = 3'd1;
    localparam logic [2:0]  PSC_TOP_CODE = 3'd7;
    localparam logic [31:0] CTRL_EN_MASK  = 32'(1) << BIT_ENABLE;
    localparam logic [31:0] CTRL_RLD_MASK = 32'(1) << BIT_RELOAD;
    localparam logic [31:0] CTRL_SINGLE  = 32'(1) << BIT_SINGLE;
    localparam logic [31:0] CTRL_PSC_TOP = 32'(PSC_TOP_CODE) << PRESCALE_LSB;
    localparam logic [31:0] CTRL_PSC_DIV2 = 32'(PSC_DIV2) << PRESCALE_LSB;

    localparam int RANDOM_PER_PHASE = 408;
    localparam int HOLD_CYCLES      = 120;

    typedef struct packed {
        logic [31:0] rd;
        logic        irq0;
        logic        irq1;
    } timer_result_t;

    typedef struct packed {
        logic [1:0]  req;
        logic [5:0]  off;
        logic [31:0] data;
        logic        typed;
        logic [31:0] rd;
        logic        irq0;
        logic        irq1;
    } dir_row_t;

    // Directed items; rows with the typed flag carry their own expected result.
    localparam int DIR_ROWS = 26;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // Everything reads zero out of reset, as do holes, misaligned offsets
        // and the idle request code.
        '{REQ_READ,  OFF_IRQ_EN,     32'h0,         1'b1, 32'h0, 1'b0, 1'b0},
        '{REQ_READ,  OFF_IRQ_STAS,   32'h0,         1'b1, 32'h0, 1'b0, 1'b0},
        '{REQ_READ,  OFF_GAP,        32'h0,         1'b1, 32'h0, 1'b0, 1'b0},
        '{REQ_READ,  OFF_MISALIGNED, 32'h0,         1'b1, 32'h0, 1'b0, 1'b0},
        '{REQ_IDLE,  OFF_IRQ_EN,     32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0, 1'b0},
        // Enable bits of absent channels are dropped.
        '{REQ_WRITE, OFF_IRQ_EN,     32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0, 1'b0},
        '{REQ_READ,  OFF_IRQ_EN,     32'h0,         1'b1, 32'h3, 1'b0, 1'b0},
        // Largest interval: high-word bits above the counter width are lost.
        '{REQ_WRITE, CH0_BASE + SUB_INTV_LO, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0, 1'b0},
        '{REQ_WRITE, CH0_BASE + SUB_INTV_HI, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0, 1'b0},
        '{REQ_READ,  CH0_BASE + SUB_INTV_HI, 32'h0, 1'b1, 32'h00FF_FFFF, 1'b0, 1'b0},
        // Top prescale code reads back as written; reload copies the interval.
        '{REQ_WRITE, CH0_BASE + SUB_CTRL, CTRL_EN_MASK | CTRL_RLD_MASK | CTRL_PSC_TOP,
          1'b1, 32'h0, 1'b0, 1'b0},
        '{REQ_READ,  CH0_BASE + SUB_CTRL, 32'h0, 1'b1, CTRL_EN_MASK | CTRL_PSC_TOP,
          1'b0, 1'b0},
        '{REQ_READ,  CH0_BASE + SUB_CURNT_LO, 32'h0, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0},
        // Zero interval in continuous mode expires on every divided tick.
        '{REQ_WRITE, CH0_BASE + SUB_INTV_HI, 32'h0, 1'b1, 32'h0, 1'b0, 1'b0},
        '{REQ_WRITE, CH0_BASE + SUB_INTV_LO, 32'h0, 1'b1, 32'h0, 1'b0, 1'b0},
        '{REQ_WRITE, CH0_BASE + SUB_CTRL, CTRL_EN_MASK | CTRL_RLD_MASK,
          1'b1, 32'h0, 1'b0, 1'b0},
        '{REQ_TICK,  6'h3F, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b1, 1'b0},
        // Single shot on channel one, divide by two, from an interval of two.
        '{REQ_WRITE, CH1_BASE + SUB_INTV_LO, 32'h2, 1'b0, 32'h0, 1'b0, 1'b0},
        '{REQ_WRITE, CH1_BASE + SUB_CTRL,
          CTRL_SINGLE | CTRL_RLD_MASK | CTRL_EN_MASK | CTRL_PSC_DIV2,
          1'b0, 32'h0, 1'b0, 1'b0},
        '{REQ_TICK,  6'h00, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{REQ_TICK,  6'h00, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{REQ_TICK,  6'h00, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{REQ_TICK,  6'h00, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
        // A one in the status register clears only that channel.
        '{REQ_WRITE, OFF_IRQ_STAS, 32'h2, 1'b0, 32'h0, 1'b0, 1'b0},
        '{REQ_WRITE, CH0_BASE + SUB_CTRL, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
        '{REQ_WRITE, OFF_IRQ_STAS, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0, 1'b0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  req_type = REQ_TICK;
    logic [5:0]  reg_offset = '0;
    logic [31:0] write_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] read_data;
    logic        irq_timer0;
    logic        irq_timer1;

    // Timer state as the checker sees it.
    logic [CW-1:0] ch_interval [NUM_CH];
    logic [CW-1:0] ch_count [NUM_CH];
    logic          ch_enable [NUM_CH];
    logic          ch_single [NUM_CH];
    logic [2:0]    ch_psc_code [NUM_CH];
    logic [4:0]    ch_psc_count [NUM_CH];
    logic [1:0]    irq_en_bits;
    logic [1:0]    irq_pend_bits;

    timer_result_t expected_results [$];
    int error_count = 0;
    int send_idle_pct = 10;
    int recv_idle_pct = 69;
    int rx_hold_cycles = 0;
    int hold_requests = 0;
    int hold_served = 0;

    dual_down_counter_timer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .reg_offset (reg_offset),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data),
        .irq_timer0 (irq_timer0),
        .irq_timer1 (irq_timer1)
    );

    always #1 clk = ~clk;

    // One tick of a channel: prescale, then decrement, expire and reload or stop.
    function automatic void tick_channel(int c);
        logic [2:0] code;
        if (!ch_enable[c])
            return;
        code = (ch_psc_code[c] > MAX_PRESCALE_CODE) ? MAX_PRESCALE_CODE : ch_psc_code[c];
        ch_psc_count[c] = ch_psc_count[c] + 5'd1;
        if (ch_psc_count[c] < (5'd1 << code))
            return;
        ch_psc_count[c] = '0;
        if (ch_count[c] > 1) begin
            ch_count[c] = ch_count[c] - 1'b1;
            return;
        end
        irq_pend_bits[c] = 1'b1;
        if (ch_single[c]) begin
            ch_count[c]  = '0;
            ch_enable[c] = 1'b0;
        end
        else begin
            ch_count[c] = ch_interval[c];
        end
    endfunction

    // Applies one item to the timer state and returns the result it causes.
    function automatic timer_result_t predict_timer(logic [1:0] req, logic [5:0] off,
                                                    logic [31:0] data);
        timer_result_t res;
        logic [5:0] rel;
        logic [4:0] sub;
        int ch;
        logic is_ch;
        logic aligned;
        res = '0;
        rel = off - OFF_CH_BASE;
        sub = rel[4:0];
        ch = int'(rel >> CH_STRIDE_LOG2);
        is_ch = (off >= OFF_CH_BASE) && (ch < NUM_CH) && (sub <= SUB_CURNT_HI);
        aligned = (off[1:0] == 2'b00);
        if (req == REQ_TICK) begin
            for (int c = 0; c < NUM_CH; c++)
                tick_channel(c);
        end
        else if (aligned && req == REQ_READ) begin
            if (off == OFF_IRQ_EN)
                res.rd = 32'(irq_en_bits);
            else if (off == OFF_IRQ_STAS)
                res.rd = 32'(irq_pend_bits);
            else if (is_ch) begin
                case (sub)
                    SUB_CTRL: begin
                        res.rd[BIT_ENABLE] = ch_enable[ch];
                        res.rd[BIT_SINGLE] = ch_single[ch];
                        res.rd[PRESCALE_MSB:PRESCALE_LSB] = ch_psc_code[ch];
                    end
                    SUB_INTV_LO:  res.rd = ch_interval[ch][31:0];
                    SUB_INTV_HI:  res.rd = 32'(ch_interval[ch] >> 32);
                    SUB_CURNT_LO: res.rd = ch_count[ch][31:0];
                    SUB_CURNT_HI: res.rd = 32'(ch_count[ch] >> 32);
                    default:      res.rd = '0;
                endcase
            end
        end
        else if (aligned && req == REQ_WRITE) begin
            if (off == OFF_IRQ_EN)
                irq_en_bits = data[1:0];
            else if (off == OFF_IRQ_STAS)
                irq_pend_bits = irq_pend_bits & ~data[1:0];
            else if (is_ch) begin
                case (sub)
                    SUB_CTRL: begin
                        ch_enable[ch]    = data[BIT_ENABLE];
                        ch_single[ch]    = data[BIT_SINGLE];
                        ch_psc_code[ch]  = data[PRESCALE_MSB:PRESCALE_LSB];
                        ch_psc_count[ch] = '0;
                        if (data[BIT_RELOAD])
                            ch_count[ch] = ch_interval[ch];
                    end
                    SUB_INTV_LO:  ch_interval[ch][31:0]    = data;
                    SUB_INTV_HI:  ch_interval[ch][CW-1:32] = data[CW-33:0];
                    SUB_CURNT_LO: ch_count[ch][31:0]       = data;
                    SUB_CURNT_HI: ch_count[ch][CW-1:32]    = data[CW-33:0];
                    default: ;
                endcase
            end
        end
        res.irq0 = irq_pend_bits[0] & irq_en_bits[0];
        res.irq1 = irq_pend_bits[1] & irq_en_bits[1];
        return res;
    endfunction

    // Offers one item, waits for it to be taken and queues its expected result.
    task automatic send_item(logic [1:0] req, logic [5:0] off, logic [31:0] data,
                             logic typed, timer_result_t typed_result);
        timer_result_t predicted;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid   <= 1'b1;
        req_type   <= req;
        reg_offset <= off;
        write_data <= data;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = predict_timer(req, off, data);
        expected_results.push_back(typed ? typed_result : predicted);
    endtask

    // Stops offering items until every expected result item has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    // Random items, mostly well-formed register traffic around a stream of ticks.
    task automatic run_random_phase(int tx_pct, int rx_pct);
        logic [1:0]  req;
        logic [5:0]  off;
        logic [31:0] data;
        logic [4:0]  sub;
        int kind;
        int pick;
        send_idle_pct = tx_pct;
        recv_idle_pct = rx_pct;
        for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            // Halfway through, the receiver holds off so the block backs up.
            if (i == RANDOM_PER_PHASE / 2)
                hold_requests++;
            kind = $urandom_range(0, 99);
            data = $urandom;
            off  = 6'($urandom_range(0, 63));
            req  = REQ_TICK;
            if (kind >= 45 && kind < 88) begin
                req  = (kind < 65) ? REQ_READ : REQ_WRITE;
                pick = $urandom_range(0, 10);
                if (pick == 0)
                    off = OFF_IRQ_EN;
                else if (pick == 1)
                    off = OFF_IRQ_STAS;
                else begin
                    // Channel one has no reachable counter high word.
                    pick = pick - 2;
                    case (pick % 5)
                        0:       sub = SUB_CTRL;
                        1:       sub = SUB_INTV_LO;
                        2:       sub = SUB_INTV_HI;
                        3:       sub = SUB_CURNT_LO;
                        default: sub = SUB_CURNT_HI;
                    endcase
                    off = ((pick >= 5) ? CH1_BASE : CH0_BASE) + sub;
                    // Keep counts short and channels mostly running.
                    case (sub)
                        SUB_CTRL: begin
                            if ($urandom_range(0, 99) < 85)
                                data[BIT_ENABLE] = 1'b1;
                            if ($urandom_range(0, 1) == 0)
                                data[PRESCALE_MSB:PRESCALE_LSB] = 3'($urandom_range(0, 2));
                        end
                        SUB_INTV_LO, SUB_CURNT_LO: begin
                            if ($urandom_range(0, 99) < 70)
                                data = $urandom_range(0, 12);
                        end
                        default: begin
                            if ($urandom_range(0, 99) < 80)
                                data = '0;
                        end
                    endcase
                end
            end
            else if (kind >= 88) begin
                req = 2'($urandom_range(0, 3));
            end
            send_item(req, off, data, 1'b0, '0);
        end
        wait_drained();
    endtask

    // Receiver: random stalls, or a long hold when one is requested.
    always @(posedge clk) begin
        if (hold_served != hold_requests) begin
            hold_served    = hold_requests;
            rx_hold_cycles = HOLD_CYCLES;
        end
        if (rx_hold_cycles > 0) begin
            out_ready <= 1'b0;
            rx_hold_cycles = rx_hold_cycles - 1;
        end
        else begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Each result item is checked against the oldest expectation.
    always @(posedge clk) begin : check_results
        timer_result_t want;
        if (out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result item with no expected item waiting");
                error_count++;
            end
            else begin
                want = expected_results.pop_front();
                if (read_data !== want.rd) begin
                    $error("read_data: expected %h, got %h", want.rd, read_data);
                    error_count++;
                end
                if (irq_timer0 !== want.irq0) begin
                    $error("irq_timer0: expected %b, got %b", want.irq0, irq_timer0);
                    error_count++;
                end
                if (irq_timer1 !== want.irq1) begin
                    $error("irq_timer1: expected %b, got %b", want.irq1, irq_timer1);
                    error_count++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, then three random phases.
    initial begin
        timer_result_t typed_result;
        for (int c = 0; c < NUM_CH; c++) begin
            ch_interval[c]  = '0;
            ch_count[c]     = '0;
            ch_enable[c]    = 1'b0;
            ch_single[c]    = 1'b0;
            ch_psc_code[c]  = '0;
            ch_psc_count[c] = '0;
        end
        irq_en_bits   = '0;
        irq_pend_bits = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            typed_result = '{DIRECTED[i].rd, DIRECTED[i].irq0, DIRECTED[i].irq1};
            send_item(DIRECTED[i].req, DIRECTED[i].off, DIRECTED[i].data,
                      DIRECTED[i].typed, typed_result);
        end
        wait_drained();

        run_random_phase(10, 69);
        run_random_phase(69, 10);
        run_random_phase(0, 0);

        // Let any stray result item show up before the verdict.
        repeat (8) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #500000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/dct_pkg.sv
rtl/dual_down_counter_timer.sv
rtl/dct_checker.sv
dv/tb_dual_down_counter_timer.sv
